// ===== hdl/lphm_pkg.sv =====
// Package for the linear probing hash map: constants, request/result
// types, status and operation codes, state enum and the key mixing hash.
// Depends on nothing.
package lphm_pkg;

	localparam int CAPACITY_DEF   = 1024;
	localparam int VALUE_BITS_DEF = 32;

	localparam logic [1:0] OP_FIND   = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_ERASE  = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOTFOUND = 3'd1;
	localparam logic [2:0] ST_DUP      = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_RESERVED = 3'd4;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] key;
		logic [31:0] value_in;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] value_out;
		logic [9:0]  slot_index;
		logic [9:0]  entry_count;
	} rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_HASH, S_PROBE_RD, S_PROBE_CHK,
		S_SH_RD, S_SH_HASH, S_SH_CHK, S_SH_DONE, S_OUT
	} state_t;

	function automatic logic [31:0] mix32(input logic [31:0] k);
		logic [31:0] a;
		a = k;
		a = (a + 32'h7ed55d16) + (a << 12);
		a = (a ^ 32'hc761c23c) ^ (a >> 19);
		a = (a + 32'h165667b1) + (a << 5);
		a = (a + 32'hd3a2646c) ^ (a << 9);
		a = (a + 32'hfd7046c5) + (a << 3);
		a = (a ^ 32'hb55a4f09) ^ (a >> 16);
		return a;
	endfunction

endpackage

// ===== hdl/linear_probe_hash_map.sv =====
// Linear probing hash map (open addressing, backward-shift erase).
// Requests (operation, key, value_in) enter on req_valid/req_stall; one
// result (status, value_out, slot_index, entry_count) leaves per request on
// rsp_valid/rsp_stall. A single write enable loads the reserved marker key.
// One request is worked at a time. Each probe slot takes a memory read
// state and a compare state after the hash state. An erase hit then walks
// the slots after it while shifting entries back, through a read, a hash
// and a check state for each occupied slot, until an empty slot ends the
// walk. Clear writes one slot a cycle through the single memory write
// port. After the result leaves, the block passes from the output state
// back to idle before it takes the next request.
// After reset the block runs a clearing pass over all CAPACITY slots, with
// the request channel stalled, before taking its first request.
// The result sits in an output register; while the receiver stalls it holds
// and the block takes no new request until it is taken.
// Inserts are refused as full when twice (count + 1) exceeds CAPACITY.
module linear_probe_hash_map #(
	parameter int CAPACITY   = lphm_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = lphm_pkg::VALUE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [31:0]      cfg_wdata,
	input  logic             req_valid,
	output logic             req_stall,
	input  lphm_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output lphm_pkg::rsp_t   rsp
);
	localparam int AW = $clog2(CAPACITY);
	localparam int MW = 32 + VALUE_BITS;
	localparam int CW = AW + 1;

	lphm_pkg::state_t state_q, state_d;
	logic [31:0]     marker_q;
	lphm_pkg::req_t  req_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   ptr_q, hole_q, scan_q;
	logic [CW-1:0]   steps_q;
	logic [AW-1:0]   home_q;
	logic [MW-1:0]   ent_q;
	lphm_pkg::rsp_t  rsp_q;
	logic            rsp_valid_q;

	logic            mem_we;
	logic [AW-1:0]   mem_waddr, mem_raddr;
	logic [MW:0]     mem_wdata, mem_rdata;

	lphm_slot_mem #(.AW(AW), .DW(MW)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	logic            rd_occ;
	logic [31:0]     rd_key;
	logic [MW-1:0]   rd_ent;
	assign rd_occ = mem_rdata[MW];
	assign rd_key = mem_rdata[MW-1:VALUE_BITS];
	assign rd_ent = mem_rdata[MW-1:0];

	logic [31:0] req_hash, rd_hash;
	assign req_hash = lphm_pkg::mix32(req_q.key);
	assign rd_hash  = lphm_pkg::mix32(rd_key);

	logic [VALUE_BITS-1:0] val_in_trunc;
	assign val_in_trunc = VALUE_BITS'(req_q.value_in);

	// Shift test: does the entry at scan_q (home home_q) move into hole_q.
	logic move_ok;
	always_comb begin
		if (scan_q > hole_q) begin
			move_ok = (home_q <= hole_q) || (home_q > scan_q);
		end else if (scan_q < hole_q) begin
			move_ok = (home_q <= hole_q) && (home_q > scan_q);
		end else begin
			move_ok = 1'b0;
		end
	end

	logic [31:0] value_ext;
	always_comb begin
		value_ext = 32'(rd_ent[VALUE_BITS-1:0]);
	end

	logic accept;
	assign req_stall = (state_q != lphm_pkg::S_IDLE) || rsp_valid_q;
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	logic        finish;
	logic [2:0]  fin_status;
	logic [31:0] fin_value;
	logic [AW-1:0] fin_slot;
	logic [CW-1:0] count_d;
	logic [AW-1:0] ptr_d, hole_d, scan_d, home_d;
	logic [CW-1:0] steps_d;
	logic [MW-1:0] ent_d;

	always_comb begin
		state_d    = state_q;
		mem_we     = 1'b0;
		mem_waddr  = ptr_q;
		mem_wdata  = '0;
		mem_raddr  = ptr_q;
		finish     = 1'b0;
		fin_status = lphm_pkg::ST_OK;
		fin_value  = '0;
		fin_slot   = '0;
		count_d    = count_q;
		ptr_d      = ptr_q;
		hole_d     = hole_q;
		scan_d     = scan_q;
		home_d     = home_q;
		steps_d    = steps_q;
		ent_d      = ent_q;
		unique case (state_q)
			lphm_pkg::S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				ptr_d     = ptr_q + AW'(1);
				if (ptr_q == AW'(CAPACITY - 1)) begin
					if (req_q.operation == lphm_pkg::OP_CLEAR && steps_q[0]) begin
						finish  = 1'b1;
						count_d = '0;
					end else begin
						state_d = lphm_pkg::S_IDLE;
					end
				end
			end
			lphm_pkg::S_IDLE: begin
				if (accept) begin
					state_d = lphm_pkg::S_HASH;
				end
			end
			lphm_pkg::S_HASH: begin
				ptr_d   = req_hash[AW-1:0];
				steps_d = '0;
				if (req_q.operation == lphm_pkg::OP_CLEAR) begin
					ptr_d   = '0;
					steps_d = CW'(1);
					state_d = lphm_pkg::S_CLEAR;
				end else if (req_q.key == marker_q) begin
					finish     = 1'b1;
					fin_status = lphm_pkg::ST_RESERVED;
				end else if (req_q.operation == lphm_pkg::OP_INSERT &&
						({count_q, 1'b0} + (CW+1)'(2)) > (CW+1)'(CAPACITY)) begin
					finish     = 1'b1;
					fin_status = lphm_pkg::ST_FULL;
				end else begin
					state_d = lphm_pkg::S_PROBE_RD;
				end
			end
			lphm_pkg::S_PROBE_RD: begin
				state_d = lphm_pkg::S_PROBE_CHK;
			end
			lphm_pkg::S_PROBE_CHK: begin
				if (!rd_occ || rd_key == req_q.key) begin
					if (!rd_occ) begin
						if (req_q.operation == lphm_pkg::OP_INSERT) begin
							mem_we    = 1'b1;
							mem_waddr = ptr_q;
							mem_wdata = {1'b1, req_q.key, val_in_trunc};
							count_d   = count_q + CW'(1);
							fin_slot  = ptr_q;
						end else begin
							fin_status = lphm_pkg::ST_NOTFOUND;
						end
						finish = 1'b1;
					end else begin
						unique case (req_q.operation)
							lphm_pkg::OP_FIND: begin
								finish    = 1'b1;
								fin_value = value_ext;
								fin_slot  = ptr_q;
							end
							lphm_pkg::OP_INSERT: begin
								finish     = 1'b1;
								fin_status = lphm_pkg::ST_DUP;
								fin_slot   = ptr_q;
							end
							default: begin
								// Erase hit: start the backward shift.
								hole_d  = ptr_q;
								scan_d  = ptr_q + AW'(1);
								steps_d = '0;
								state_d = lphm_pkg::S_SH_RD;
							end
						endcase
					end
				end else if (steps_q == CW'(CAPACITY - 1)) begin
					finish     = 1'b1;
					fin_status = (req_q.operation == lphm_pkg::OP_INSERT) ?
						lphm_pkg::ST_FULL : lphm_pkg::ST_NOTFOUND;
				end else begin
					ptr_d   = ptr_q + AW'(1);
					steps_d = steps_q + CW'(1);
					state_d = lphm_pkg::S_PROBE_RD;
				end
			end
			lphm_pkg::S_SH_RD: begin
				mem_raddr = scan_q;
				state_d   = lphm_pkg::S_SH_HASH;
			end
			lphm_pkg::S_SH_HASH: begin
				if (!rd_occ || steps_q == CW'(CAPACITY)) begin
					state_d = lphm_pkg::S_SH_DONE;
				end else begin
					home_d  = rd_hash[AW-1:0];
					ent_d   = rd_ent;
					state_d = lphm_pkg::S_SH_CHK;
				end
			end
			lphm_pkg::S_SH_CHK: begin
				if (move_ok) begin
					mem_we    = 1'b1;
					mem_waddr = hole_q;
					mem_wdata = {1'b1, ent_q};
					hole_d    = scan_q;
				end
				scan_d  = scan_q + AW'(1);
				steps_d = steps_q + CW'(1);
				state_d = lphm_pkg::S_SH_RD;
			end
			lphm_pkg::S_SH_DONE: begin
				mem_we    = 1'b1;
				mem_waddr = hole_q;
				mem_wdata = '0;
				finish    = 1'b1;
				fin_slot  = ptr_q;
				if (count_q != '0) begin
					count_d = count_q - CW'(1);
				end
			end
			lphm_pkg::S_OUT: begin
				if (!rsp_valid_q) begin
					state_d = lphm_pkg::S_IDLE;
				end
			end
			default: state_d = lphm_pkg::S_IDLE;
		endcase
		if (finish) begin
			state_d = lphm_pkg::S_OUT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lphm_pkg::S_CLEAR;
			marker_q    <= '0;
			count_q     <= '0;
			ptr_q       <= '0;
			steps_q     <= '0;
			rsp_valid_q <= 1'b0;
			req_q       <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ptr_q   <= ptr_d;
			steps_q <= steps_d;
			if (cfg_we) begin
				marker_q <= cfg_wdata;
			end
			if (accept) begin
				req_q <= req;
			end
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		hole_q <= hole_d;
		scan_q <= scan_d;
		home_q <= home_d;
		ent_q  <= ent_d;
		if (finish) begin
			rsp_q.status      <= fin_status;
			rsp_q.value_out   <= fin_value;
			rsp_q.slot_index  <= 10'(fin_slot);
			rsp_q.entry_count <= 10'(count_d);
		end
	end
endmodule

// ===== hdl/lphm_slot_mem.sv =====
// Slot memory of the hash map: occupied bit, key and value per slot.
// One write port and one registered read port. Depends on nothing.
module lphm_slot_mem #(
	parameter int AW = 10,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW:0]   rdata
);
	logic [DW:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/lphm_checker.sv =====
// Port-level checks for linear_probe_hash_map, bound to the top level.
// Depends on lphm_pkg.
module lphm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input lphm_pkg::rsp_t rsp
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_no_req_while_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall)
		else $error("request taken while result pending");

	// Only one request is worked at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request taken while one is in flight");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status <= lphm_pkg::ST_RESERVED)
		else $error("bad status code");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != lphm_pkg::ST_OK |-> rsp.value_out == '0)
		else $error("value on failed request");
endmodule

bind linear_probe_hash_map lphm_checker u_lphm_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
	.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
);
